// ===== rtl/core/lpe_pkg.sv =====
package lpe_pkg;

  // Number format: signed fixed point, FRAC_BITS fractional bits, 1.0 = 2**FRAC_BITS.
  localparam int FRAC_BITS = 14;
  localparam int MAX_ORDER = 31;

  // Port widths fixed by the interface.
  localparam int ORDER_W = 5;
  localparam int SMP_W   = 16;

  // Values of the recurrence lie in [-1.0, +1.0].
  localparam int VAL_W = FRAC_BITS + 2;
  // Step index k runs up to MAX_ORDER + 1.
  localparam int K_W = $clog2(MAX_ORDER + 2);
  // |(2k-1)*p - (k-1)*prev| stays below 3 * MAX_ORDER * 1.0.
  localparam int MAG_W  = FRAC_BITS + $clog2(3 * MAX_ORDER + 1);
  localparam int TERM_W = MAG_W + 1;
  // Shared multiplier operands and product.
  localparam int MUL_W  = MAG_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  // Reciprocal scale for the divide by k.
  localparam int RECIP_SH = MAG_W;

  localparam logic signed [VAL_W-1:0] ONE_FX = VAL_W'(2 ** FRAC_BITS);
  localparam longint RECIP_ONE = longint'(1) << RECIP_SH;

  // Microprogram counter.
  localparam int UPC_W = 3;
  localparam logic [UPC_W-1:0] UPC_LOOP = UPC_W'(0);
  localparam logic [UPC_W-1:0] UPC_FIN  = UPC_W'(7);

  typedef enum logic [2:0] {
    OP_NOP,  // no datapath action
    OP_MXC,  // prod <= x * cur
    OP_MP,   // prod <= (2k-1) * p, p = prod >> FRAC_BITS toward zero
    OP_MPV,  // acc <= prod, prod <= (k-1) * prev
    OP_TRM,  // term = acc - prod, split into sign and magnitude
    OP_MR,   // prod <= |term| * recip(k)
    OP_MQ,   // q <= prod >> RECIP_SH, prod <= q * k
    OP_COR   // fix up quotient, saturate, advance the recurrence
  } lpe_op_t;

  typedef enum logic [1:0] {
    JC_NEXT,     // fall through
    JC_IF_DONE,  // jump when k exceeds the order
    JC_ALWAYS,   // unconditional jump
    JC_WAIT_OUT  // hold until the output register is free, then finish
  } lpe_jcond_t;

  typedef struct packed {
    lpe_op_t          op;
    lpe_jcond_t       jcond;
    logic [UPC_W-1:0] target;
  } lpe_uinstr_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } lpe_state_t;

  // Sequencer to datapath.
  typedef struct packed {
    lpe_op_t op;
    logic    finish;
  } lpe_ctrl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic k_gt_n;
  } lpe_status_t;

  // The control store: one pass of the loop is one recurrence step.
  function automatic lpe_uinstr_t ucode_word(input logic [UPC_W-1:0] upc);
    lpe_uinstr_t w;
    unique case (upc)
      3'd0: w = '{op: OP_MXC, jcond: JC_IF_DONE,  target: UPC_FIN};
      3'd1: w = '{op: OP_MP,  jcond: JC_NEXT,     target: UPC_LOOP};
      3'd2: w = '{op: OP_MPV, jcond: JC_NEXT,     target: UPC_LOOP};
      3'd3: w = '{op: OP_TRM, jcond: JC_NEXT,     target: UPC_LOOP};
      3'd4: w = '{op: OP_MR,  jcond: JC_NEXT,     target: UPC_LOOP};
      3'd5: w = '{op: OP_MQ,  jcond: JC_NEXT,     target: UPC_LOOP};
      3'd6: w = '{op: OP_COR, jcond: JC_ALWAYS,   target: UPC_LOOP};
      3'd7: w = '{op: OP_NOP, jcond: JC_WAIT_OUT, target: UPC_LOOP};
    endcase
    return w;
  endfunction

  // floor(2**RECIP_SH / k) for k >= 2; the estimate is at most one low.
  function automatic logic [MAG_W-1:0] recip_of(input logic [K_W-1:0] k);
    longint r;
    case (k)
      2:  r = RECIP_ONE / 2;   3:  r = RECIP_ONE / 3;   4:  r = RECIP_ONE / 4;
      5:  r = RECIP_ONE / 5;   6:  r = RECIP_ONE / 6;   7:  r = RECIP_ONE / 7;
      8:  r = RECIP_ONE / 8;   9:  r = RECIP_ONE / 9;   10: r = RECIP_ONE / 10;
      11: r = RECIP_ONE / 11;  12: r = RECIP_ONE / 12;  13: r = RECIP_ONE / 13;
      14: r = RECIP_ONE / 14;  15: r = RECIP_ONE / 15;  16: r = RECIP_ONE / 16;
      17: r = RECIP_ONE / 17;  18: r = RECIP_ONE / 18;  19: r = RECIP_ONE / 19;
      20: r = RECIP_ONE / 20;  21: r = RECIP_ONE / 21;  22: r = RECIP_ONE / 22;
      23: r = RECIP_ONE / 23;  24: r = RECIP_ONE / 24;  25: r = RECIP_ONE / 25;
      26: r = RECIP_ONE / 26;  27: r = RECIP_ONE / 27;  28: r = RECIP_ONE / 28;
      29: r = RECIP_ONE / 29;  30: r = RECIP_ONE / 30;  31: r = RECIP_ONE / 31;
      32: r = RECIP_ONE / 32;  33: r = RECIP_ONE / 33;  34: r = RECIP_ONE / 34;
      35: r = RECIP_ONE / 35;  36: r = RECIP_ONE / 36;  37: r = RECIP_ONE / 37;
      38: r = RECIP_ONE / 38;  39: r = RECIP_ONE / 39;  40: r = RECIP_ONE / 40;
      41: r = RECIP_ONE / 41;  42: r = RECIP_ONE / 42;  43: r = RECIP_ONE / 43;
      44: r = RECIP_ONE / 44;  45: r = RECIP_ONE / 45;  46: r = RECIP_ONE / 46;
      47: r = RECIP_ONE / 47;  48: r = RECIP_ONE / 48;  49: r = RECIP_ONE / 49;
      50: r = RECIP_ONE / 50;  51: r = RECIP_ONE / 51;  52: r = RECIP_ONE / 52;
      53: r = RECIP_ONE / 53;  54: r = RECIP_ONE / 54;  55: r = RECIP_ONE / 55;
      56: r = RECIP_ONE / 56;  57: r = RECIP_ONE / 57;  58: r = RECIP_ONE / 58;
      59: r = RECIP_ONE / 59;  60: r = RECIP_ONE / 60;  61: r = RECIP_ONE / 61;
      62: r = RECIP_ONE / 62;  63: r = RECIP_ONE / 63;
      default: r = 0;
    endcase
    return MAG_W'(r);
  endfunction

endpackage

// ===== rtl/core/lpe_sequencer.sv =====
module lpe_sequencer
  import lpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        out_free,
  input  lpe_status_t status,
  output lpe_ctrl_t   ctrl,
  output logic        idle
);

  lpe_state_t       state, state_next;
  logic [UPC_W-1:0] upc, upc_next;
  lpe_uinstr_t      uinstr;

  assign uinstr = ucode_word(upc);

  // Next state and microprogram counter.
  always_comb begin
    state_next = state;
    upc_next   = upc;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RUN;
          upc_next   = UPC_LOOP;
        end
      end
      ST_RUN: begin
        unique case (uinstr.jcond)
          JC_NEXT:     upc_next = upc + UPC_W'(1);
          JC_IF_DONE:  upc_next = status.k_gt_n ? uinstr.target : upc + UPC_W'(1);
          JC_ALWAYS:   upc_next = uinstr.target;
          JC_WAIT_OUT: begin
            if (out_free) begin
              state_next = ST_IDLE;
            end
          end
        endcase
      end
    endcase
  end

  // Outputs.
  always_comb begin
    ctrl.op     = OP_NOP;
    ctrl.finish = 1'b0;
    idle        = 1'b0;
    unique case (state)
      ST_IDLE: idle = 1'b1;
      ST_RUN: begin
        ctrl.op     = uinstr.op;
        ctrl.finish = (uinstr.jcond == JC_WAIT_OUT) && out_free;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      upc   <= UPC_LOOP;
    end else begin
      state <= state_next;
      upc   <= upc_next;
    end
  end

endmodule

// ===== rtl/core/lpe_datapath.sv =====
module lpe_datapath
  import lpe_pkg::*;
(
  input  logic                     clk,
  input  logic                     load,
  input  logic signed [SMP_W-1:0]  x_sample,
  input  logic [ORDER_W-1:0]       order,
  input  lpe_ctrl_t                ctrl,
  output lpe_status_t              status,
  output logic signed [VAL_W-1:0]  result
);

  logic signed [VAL_W-1:0]  x_q, prev, cur;
  logic [K_W-1:0]           k, n;
  logic signed [PROD_W-1:0] prod, prod_bias;
  logic signed [TERM_W-1:0] acc, term;
  logic [MAG_W-1:0]         tmag, q, rem, q_fix;
  logic                     tneg;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [VAL_W-1:0]  p_val, x_sat, mag_sat, cur_step;
  logic [K_W:0]             coef_odd;
  logic [K_W-1:0]           order_clamped;

  // Input sample clamped to [-1.0, +1.0].
  always_comb begin
    if (int'(x_sample) > int'(ONE_FX)) begin
      x_sat = ONE_FX;
    end else if (int'(x_sample) < -int'(ONE_FX)) begin
      x_sat = -ONE_FX;
    end else begin
      x_sat = VAL_W'(x_sample);
    end
  end

  assign order_clamped = (K_W'(order) > K_W'(MAX_ORDER)) ? K_W'(MAX_ORDER) : K_W'(order);

  // x * cur scaled back by 1.0, rounded toward zero.
  assign prod_bias = prod + (prod[PROD_W-1] ? PROD_W'(ONE_FX - 1) : PROD_W'(0));
  assign p_val     = VAL_W'(prod_bias >>> FRAC_BITS);
  assign coef_odd  = {k, 1'b0} - (K_W+1)'(1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.op)
      OP_MXC: begin
        mul_a = MUL_W'(x_q);
        mul_b = MUL_W'(cur);
      end
      OP_MP: begin
        mul_a = MUL_W'(coef_odd);
        mul_b = MUL_W'(p_val);
      end
      OP_MPV: begin
        mul_a = MUL_W'(k - K_W'(1));
        mul_b = MUL_W'(prev);
      end
      OP_MR: begin
        mul_a = MUL_W'(tmag);
        mul_b = MUL_W'(recip_of(k));
      end
      OP_MQ: begin
        mul_a = MUL_W'(prod[RECIP_SH +: MAG_W]);
        mul_b = MUL_W'(k);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign term = acc - TERM_W'(prod);

  // Quotient fix-up: the reciprocal estimate is exact or one low.
  assign rem     = tmag - MAG_W'(prod);
  assign q_fix   = q + MAG_W'(rem >= MAG_W'(k));
  assign mag_sat = (q_fix > MAG_W'(ONE_FX)) ? ONE_FX : VAL_W'(q_fix);
  assign cur_step = tneg ? -mag_sat : mag_sat;

  always_ff @(posedge clk) begin
    if (load) begin
      x_q  <= x_sat;
      prev <= ONE_FX;
      cur  <= (order_clamped == K_W'(0)) ? ONE_FX : x_sat;
      k    <= K_W'(2);
      n    <= order_clamped;
    end else begin
      case (ctrl.op)
        OP_MXC, OP_MP, OP_MR: prod <= mul_a * mul_b;
        OP_MPV: begin
          acc  <= TERM_W'(prod);
          prod <= mul_a * mul_b;
        end
        OP_TRM: begin
          tneg <= term[TERM_W-1];
          tmag <= MAG_W'(term[TERM_W-1] ? -term : term);
        end
        OP_MQ: begin
          q    <= prod[RECIP_SH +: MAG_W];
          prod <= mul_a * mul_b;
        end
        OP_COR: begin
          prev <= cur;
          cur  <= cur_step;
          k    <= k + K_W'(1);
        end
        default: ;
      endcase
    end
  end

  assign status.k_gt_n = k > n;
  assign result        = cur;

endmodule

// ===== rtl/core/legendre_polynomial_eval_unit.sv =====
// Legendre polynomial evaluator. Each word on the input channel is a sample x in signed
// fixed point with 14 fractional bits (16384 is 1.0); values outside [-1, 1] are clamped.
// Each sample yields one output word holding P_n(x) in the same format, clamped to [-1, 1],
// where n is the order register (written through cfg_wr_en / cfg_wr_data while the unit is
// idle). Order 0 returns 1.0 and order 1 returns the clamped x. Higher orders run Bonnet's
// recurrence k*P_k = (2k-1)*x*P_(k-1) - (k-1)*P_(k-2), truncating the product x*P_(k-1) and
// the division by k toward zero and clamping each P_k to [-1, 1]. The unit works on one
// sample at a time: a small microprogram drives one shared 22x22 multiplier, and each
// recurrence step runs three products for the recurrence, a reciprocal multiply and a
// back-multiply for the exact divide by k, plus a subtract step and a fix-up step.
// The last step of a sample is held for as long as the previous result still waits in
// the output register. A new sample is taken as soon as the unit is idle, even while the
// previous result still waits in the output register.
module legendre_polynomial_eval_unit
  import lpe_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [ORDER_W-1:0]       cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [SMP_W-1:0]  x_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [SMP_W-1:0]  poly_value
);

  logic [ORDER_W-1:0]      order;
  logic                    in_accept;
  logic                    out_free;
  logic                    idle;
  lpe_ctrl_t               ctrl;
  lpe_status_t             status;
  logic signed [VAL_W-1:0] result;

  // The order register must only be written between samples; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      order <= '0;
    end else if (cfg_wr_en) begin
      order <= cfg_wr_data;
    end
  end

  assign in_ready  = idle;
  assign in_accept = in_valid && in_ready;
  // The output register can take a new result when empty or being drained this cycle.
  assign out_free  = !out_valid || out_ready;

  lpe_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_accept),
    .out_free (out_free),
    .status   (status),
    .ctrl     (ctrl),
    .idle     (idle)
  );

  lpe_datapath u_dp (
    .clk      (clk),
    .load     (in_accept),
    .x_sample (x_sample),
    .order    (order),
    .ctrl     (ctrl),
    .status   (status),
    .result   (result)
  );

  // Output register: loaded when the microprogram finishes, held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      poly_value <= SMP_W'(result);
    end
  end

`ifndef ASSERT_OFF
  // A result is only written into a free output register.
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.finish |-> out_free)
    else $error("result written over a pending output word");

  // A finished result shows up on the output next cycle.
  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    ctrl.finish |=> out_valid)
    else $error("finished result not presented");

  // Once a sample is taken the unit is busy until its result is written.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !in_ready)
    else $error("unit idle right after accepting a sample");

  // Results stay within [-1.0, +1.0].
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (int'(poly_value) <= int'(ONE_FX)) && (int'(poly_value) >= -int'(ONE_FX)))
    else $error("output word outside [-1, 1]");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for the Legendre polynomial evaluation unit.
//
// Every sample word sent into the unit gives exactly one result word, P_n(x), where n is
// the order register in force when the sample was taken. The bench keeps its own copy of
// the order register, computes the expected value of each accepted sample with a
// bit-exact model of the fixed-point recurrence, and queues it. The output side pops the
// oldest entry for every accepted result word and compares.
//
// The run has two parts. A short table of probe samples comes first: the reset order,
// clamped samples, the endpoints of [-1, 1] at low and at the highest order, and a sample
// just below 1.0 at the highest order, where truncation drift is most likely to show.
// Then random phases follow, each under a fresh order value, with sample words sent in
// bursts and the output side stalled on a pattern of its own.
module testbench
  import lpe_pkg::*;
();

  localparam int NUM_PROBES   = 23;
  localparam int RANDOM_WORDS = 1200;
  // The tail wait covers the longest single sample, which comes at order 31.
  localparam int SETTLE_CYCLES = 250;

  localparam longint UNIT = longint'(1) << FRAC_BITS;

  // One row of the probe table. When has_want is clear the value comes from the model.
  typedef struct packed {
    logic [ORDER_W-1:0]      order;
    logic signed [SMP_W-1:0] x;
    logic                    has_want;
    logic signed [SMP_W-1:0] want;
  } probe_row_t;

  // A result the unit still owes us, with the sample that caused it for the log.
  typedef struct packed {
    logic [ORDER_W-1:0]      order;
    logic signed [SMP_W-1:0] x;
    logic signed [SMP_W-1:0] value;
  } owed_result_t;

  // Output-side stall patterns.
  typedef enum logic [1:0] {
    RX_OPEN,      // always ready
    RX_RANDOM,    // ready at random, with probability three in four
    RX_ALTERNATE, // ready every other cycle
    RX_CHOKE      // ready only when the tick count is a multiple of 24
  } rx_mode_t;

  localparam probe_row_t PROBES [NUM_PROBES] = '{
    // Order 0 straight out of reset: always 1.0, whatever the sample.
    '{0, 0, 1, 16384},
    '{0, -32768, 1, 16384},
    '{0, 32767, 1, 16384},
    // Order 1 returns the sample, clamped to [-1, 1].
    '{1, 32767, 1, 16384},
    '{1, -32768, 1, -16384},
    '{1, 16384, 1, 16384},
    '{1, -16384, 1, -16384},
    '{1, 1234, 1, 1234},
    '{1, 16385, 1, 16384},
    '{1, -16385, 1, -16384},
    // First real recurrence step. P_n(1) = 1 and P_n(-1) = (-1)^n hold exactly.
    '{2, 0, 0, 0},
    '{2, 16384, 1, 16384},
    '{2, -16384, 1, 16384},
    '{2, 9459, 0, 0},
    // Highest order, including clamped samples and values near 1.0; then two rows at order 3.
    '{31, 16384, 1, 16384},
    '{31, -16384, 1, -16384},
    '{31, 32767, 1, 16384},
    '{31, -32768, 1, -16384},
    '{31, 100, 0, 0},
    '{31, -1, 0, 0},
    '{31, 16383, 0, 0},
    '{3, -16384, 1, -16384},
    '{3, 5000, 0, 0}
  };

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    cfg_wr_en = 1'b0;
  logic [ORDER_W-1:0]      cfg_wr_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [SMP_W-1:0] x_sample = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [SMP_W-1:0] poly_value;

  // Order register as the bench believes it to be; reset value is 0.
  logic [ORDER_W-1:0] order_now = '0;
  owed_result_t       owed_q[$];
  owed_result_t       owed_head;
  int                 errors = 0;

  legendre_polynomial_eval_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .x_sample   (x_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .poly_value (poly_value)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop. The slowest legal run (every sample at order 31, worst gaps and stalls)
  // stays well under a third of this.
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic longint clamp_unit(input longint v);
    if (v > UNIT) begin
      return UNIT;
    end
    if (v < -UNIT) begin
      return -UNIT;
    end
    return v;
  endfunction

  // Bonnet's recurrence, k*P_k = (2k-1)*x*P_(k-1) - (k-1)*P_(k-2), in 64-bit integers.
  // SystemVerilog signed division truncates toward zero, which is what the unit does for
  // both the product rescale and the divide by k. Every P_k is clamped to [-1, 1].
  function automatic logic signed [SMP_W-1:0] legendre_at(
    input logic [ORDER_W-1:0] n_in, input logic signed [SMP_W-1:0] x_in);
    longint x, p_prev, p_cur, prod, term, k;
    int     n;
    n = (n_in > MAX_ORDER) ? MAX_ORDER : int'(n_in);
    x = clamp_unit(longint'(x_in));
    p_prev = UNIT;
    if (n == 0) begin
      return p_prev[SMP_W-1:0];
    end
    p_cur = x;
    for (k = 2; k <= n; k++) begin
      prod   = (x * p_cur) / UNIT;
      term   = (2 * k - 1) * prod - (k - 1) * p_prev;
      p_prev = p_cur;
      p_cur  = clamp_unit(term / k);
    end
    return p_cur[SMP_W-1:0];
  endfunction

  // Present one sample word and hold it until the unit takes it. Called right after a
  // rising edge; returns at the edge where the word was accepted, with valid still high
  // so that a following word can go out back to back.
  task automatic send_sample(input logic signed [SMP_W-1:0] x, input logic has_want,
                             input logic signed [SMP_W-1:0] want);
    owed_result_t owed;
    in_valid <= 1'b1;
    x_sample <= x;
    do @(posedge clk); while (!in_ready);
    owed.order = order_now;
    owed.x     = x;
    owed.value = has_want ? want : legendre_at(order_now, x);
    owed_q.push_back(owed);
  endtask

  // Stop sending and wait until every owed result word has been collected. Each sample
  // yields a result, so an empty queue means the unit has gone idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (owed_q.size() != 0) @(posedge clk);
  endtask

  // The order register may only change while the unit is idle.
  task automatic set_order(input logic [ORDER_W-1:0] ord);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ord;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    order_now = ord;
  endtask

  // Mostly samples inside [-1, 1], some at the landmark values, some anywhere in the
  // 16-bit range so that the input clamp and every bit of the port get exercised.
  function automatic logic signed [SMP_W-1:0] pick_sample();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 8) begin
      return SMP_W'($urandom_range(0, 32768) - 16384);
    end
    if (roll == 8) begin
      case ($urandom_range(0, 6))
        0: return SMP_W'(16384);
        1: return SMP_W'(-16384);
        2: return SMP_W'(16383);
        3: return SMP_W'(-16383);
        4: return SMP_W'(1);
        5: return SMP_W'(-1);
        default: return '0;
      endcase
    end
    return SMP_W'($urandom());
  endfunction

  // Output side: switch among stall patterns, each kept for a random stretch, so stalls
  // land on every step of the unit's work, with open stretches in between.
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_tick = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left = rx_left - 1;
    end
    rx_tick = rx_tick + 1;
    case (rx_mode)
      RX_OPEN:      out_ready <= 1'b1;
      RX_RANDOM:    out_ready <= ($urandom_range(0, 3) != 0);
      RX_ALTERNATE: out_ready <= rx_tick[0];
      default:      out_ready <= (rx_tick % 24 == 0);
    endcase
  end

  // Result checker: every accepted result word is matched against the oldest owed one.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: result word %0d arrived with nothing owed", $time, poly_value);
      end else begin
        owed_head = owed_q.pop_front();
        if (poly_value !== owed_head.value) begin
          errors++;
          $display("%0t: order %0d x %0d: expected %0d, got %0d", $time,
                   owed_head.order, owed_head.x, owed_head.value, poly_value);
        end
      end
    end
  end

  initial begin
    int remaining, phase, len, burst_left, gap;
    logic [ORDER_W-1:0] ord;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Probe table. The order register changes only between rows of different order,
    // after the unit has handed back everything it owes; the first rows rely on the
    // reset value of the register.
    for (int i = 0; i < NUM_PROBES; i++) begin
      if (PROBES[i].order != order_now) begin
        set_order(PROBES[i].order);
      end
      send_sample(PROBES[i].x, PROBES[i].has_want, PROBES[i].want);
    end

    // Random phases. The first two pin the extremes of the order register; after that
    // half the phases use low orders, which are quick, and half any order. Each phase
    // boundary holds the input side back until all results are in.
    remaining  = RANDOM_WORDS;
    phase      = 0;
    burst_left = 0;
    while (remaining > 0) begin
      case (phase)
        0: ord = ORDER_W'(31);
        1: ord = ORDER_W'(0);
        default: ord = $urandom_range(0, 1) ? ORDER_W'($urandom_range(0, 6))
                                             : ORDER_W'($urandom_range(0, 31));
      endcase
      set_order(ord);
      len = $urandom_range(30, 90);
      if (len > remaining) begin
        len = remaining;
      end
      repeat (len) begin
        // Bursts of back-to-back words, separated by gaps of random length; about a
        // quarter of the bursts follow the previous one with no gap at all.
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        burst_left--;
        send_sample(pick_sample(), 1'b0, '0);
      end
      remaining -= len;
      phase++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (owed_q.size() != 0) begin
      errors++;
      $display("%0t: %0d result words never arrived", $time, owed_q.size());
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
